// File: rtl/byte_pattern_match_finder_assert.svh
// assertion macros used by the checker file
// clk and arst_n must be visible where a macro is used
`ifndef BYTE_PATTERN_MATCH_FINDER_ASSERT_SVH
`define BYTE_PATTERN_MATCH_FINDER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BPMF_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpmf assertion failed");

// next-cycle implication, disabled during reset
`define BPMF_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpmf assertion failed");

`endif

// File: rtl/bpmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpmf_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int HIST_DEPTH        = MAX_PATTERN_BYTES - 1;
	localparam int CNT_W             = $clog2(MAX_PATTERN_BYTES);
	localparam int LEN_W             = 5;
	localparam int ADDR_W            = 48;
	localparam int CFG_DATA_W        = 64;
	localparam int CFG_IDX_W         = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

	// pattern bytes and clamped length (1..MAX_PATTERN_BYTES)
	typedef struct packed {
		logic [MAX_PATTERN_BYTES-1:0][7:0] pattern;
		logic [LEN_W-1:0]                  len;
	} pattern_cfg_t;

endpackage

`default_nettype wire

// File: rtl/bpmf_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module bpmf_cfg import bpmf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output pattern_cfg_t               cfg
);

	logic [CFG_DATA_W-1:0] pattern_low_q;
	logic [CFG_DATA_W-1:0] pattern_high_q;
	logic [LEN_W-1:0]      pattern_length_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= LEN_W'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// zero length acts as one, overlong length as the maximum
	always_comb begin
		cfg.pattern = {pattern_high_q, pattern_low_q};
		if (pattern_length_q == '0)
			cfg.len = LEN_W'(1);
		else if (pattern_length_q > LEN_W'(MAX_PATTERN_BYTES))
			cfg.len = LEN_W'(MAX_PATTERN_BYTES);
		else
			cfg.len = pattern_length_q;
	end

endmodule

`default_nettype wire

// File: rtl/bpmf_window.sv
`timescale 1ns / 1ps
`default_nettype none

module bpmf_window import bpmf_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         advance,
	input  wire logic [7:0]   data,
	input  wire logic         start,
	input  wire pattern_cfg_t cfg,
	output logic              hit
);

	logic [HIST_DEPTH-1:0][7:0]        hist_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [CNT_W-1:0]                  cnt_eff;
	logic [CNT_W-1:0]                  len_m1;
	logic [CNT_W-1:0]                  shamt;
	logic [MAX_PATTERN_BYTES*8-1:0]    rev_flat;
	logic [MAX_PATTERN_BYTES*8-1:0]    aligned_flat;
	logic [MAX_PATTERN_BYTES-1:0][7:0] win;

	// a new segment discards the earlier bytes
	assign cnt_eff = start ? '0 : cnt_q;
	assign len_m1  = CNT_W'(cfg.len - LEN_W'(1));
	assign shamt   = CNT_W'(LEN_W'(MAX_PATTERN_BYTES) - cfg.len);

	// align pattern so that slot k faces the byte k places back from the newest
	always_comb begin
		for (int i = 0; i < MAX_PATTERN_BYTES; i++)
			rev_flat[8*i +: 8] = cfg.pattern[MAX_PATTERN_BYTES-1-i];
		aligned_flat = rev_flat >> {shamt, 3'b000};
	end

	// window of newest bytes, newest first
	always_comb begin
		win[0] = data;
		for (int k = 1; k < MAX_PATTERN_BYTES; k++)
			win[k] = hist_q[k-1];
	end

	// parallel compare over the active slots
	always_comb begin
		hit = (cnt_eff >= len_m1);
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			if ((LEN_W'(k) < cfg.len) && (aligned_flat[8*k +: 8] != win[k]))
				hit = 1'b0;
		end
	end

	// history shift and saturating byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			cnt_q  <= '0;
		end else if (advance) begin
			hist_q[0] <= data;
			for (int k = 1; k < HIST_DEPTH; k++)
				hist_q[k] <= start ? 8'h00 : hist_q[k-1];
			cnt_q <= (cnt_eff == CNT_W'(HIST_DEPTH)) ? cnt_eff : cnt_eff + CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

// File: rtl/byte_pattern_match_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// an input transfer passes the input register and then the output register before its match can transfer
// throughput: one byte per cycle while the output is not held; the window compare runs in a single stage
// the input register and the output register stall only when the output is held
// reset: asynchronous active low; clears history, byte count, valids and sets
// pattern registers to zero and pattern length to one

module byte_pattern_match_finder import bpmf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            data_byte,
	input  wire logic [ADDR_W-1:0]     byte_address,
	input  wire logic                  segment_start,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [ADDR_W-1:0]          match_address
);

	pattern_cfg_t      cfg;
	logic              valid_s1;
	logic [7:0]        data_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              start_s1;
	logic              advance;
	logic              hit;
	logic              out_valid_q;
	logic [ADDR_W-1:0] match_address_q;

	bpmf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage handshake
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			addr_s1  <= byte_address;
			start_s1 <= segment_start;
		end
	end

	bpmf_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.data   (data_s1),
		.start  (start_s1),
		.cfg    (cfg),
		.hit    (hit)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= hit;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// address of the first matched byte, wraps modulo the address width
	always_ff @(posedge clk) begin
		if (advance && hit)
			match_address_q <= addr_s1 - ADDR_W'(cfg.len - LEN_W'(1));
	end

	assign out_valid     = out_valid_q;
	assign match_address = match_address_q;

endmodule

`default_nettype wire

// File: rtl/bpmf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "byte_pattern_match_finder_assert.svh"

module bpmf_checker import bpmf_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [ADDR_W-1:0]     match_address
);

	// a stalled result holds its address
	`BPMF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(match_address))

	// a fresh result traces back to an input transfer through the input and output registers
	`BPMF_ASSERT_IMP(a_out_latency, $rose(out_valid), $past(in_valid && in_ready, 2))

	// with the output empty the input side never stalls
	`BPMF_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind byte_pattern_match_finder bpmf_checker u_bpmf_checker (.*);

`default_nettype wire
